// ===== src/ecsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ecsm_pkg: shared types for the elliptic-curve scalar multiplier
// Working-store slot map, micro-op codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ecsm_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

  // Slots of the working store. *R = raw coordinate as given, others reduced.
  // R = running point, Q = accumulator.
  typedef enum logic [3:0] {
    SL_RXR, SL_RYR, SL_QXR, SL_QYR,
    SL_RX,  SL_RY,  SL_QX,  SL_QY,
    SL_AR,  SL_ONE, SL_NUM, SL_DEN,
    SL_R0,  SL_R1,  SL_T0,  SL_T1
  } slot_t;

  typedef enum logic [3:0] {
    OP_LDI,   // write immediate
    OP_MOV,   // copy A
    OP_ADD,   // A + B mod m
    OP_SUB,   // A - B mod m
    OP_MUL,   // A * B mod m, bit serial
    OP_MULQ,  // A * (last quotient mod m), bit serial
    OP_DIV,   // A % B, quotient kept
    OP_RED,   // A % m
    OP_CMP    // set flags from A, B
  } op_t;

endpackage

// ===== src/ecsm_if.sv =====
// ----------------------------------------------------------------------------
// ecsm_if: item channels of the elliptic-curve scalar multiplier
// Valid/ready channels for the job item and the result item.
// ----------------------------------------------------------------------------
interface ecsm_in_if #(
  parameter int SCALAR_BITS = 31,
  parameter int FIELD_BITS  = 16
);
  logic                   valid;
  logic                   ready;
  logic [SCALAR_BITS-1:0] scalar;
  logic [FIELD_BITS-1:0]  point_x;
  logic [FIELD_BITS-1:0]  point_y;

  modport source (output valid, scalar, point_x, point_y, input ready);
  modport sink   (input valid, scalar, point_x, point_y, output ready);
endinterface

interface ecsm_out_if #(
  parameter int FIELD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] result_x;
  logic [FIELD_BITS-1:0] result_y;

  modport source (output valid, result_x, result_y, input ready);
  modport sink   (input valid, result_x, result_y, output ready);
endinterface

// ===== src/ec_scalar_multiply_binary_core.sv =====
// ----------------------------------------------------------------------------
// ec_scalar_multiply_binary_core: affine elliptic-curve scalar multiplier
// Right-to-left double-and-add over a prime field, micro-sequenced around
// a 16-slot working store.
// ----------------------------------------------------------------------------
// Takes one job item (scalar k, point P) at a time and returns kP; (0,0) is
// the point at infinity, and a zero modulus gives (0,0). All field values live
// in a 16-entry working store with registered reads; a sequencer issues
// micro-ops that read it, run a shared ALU and write back. A modular multiply
// or a division step runs bit-serially, since the ALU handles one bit per
// cycle. Per scalar bit up to the highest set bit, a point op runs an
// extended-Euclid inversion. Job ready is high only while the block is idle.
module ec_scalar_multiply_binary_core #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]          cfg_data,
  ecsm_in_if.sink                        job,
  ecsm_out_if.source                     res
);
  import ecsm_pkg::*;

  localparam int CW = $clog2(FIELD_BITS);
  localparam logic [FIELD_BITS-1:0] A_RESET = FIELD_BITS'(1);
  localparam logic [FIELD_BITS-1:0] M_RESET = FIELD_BITS'(17);

  typedef enum logic [5:0] {
    ST_IDLE, ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7, ST_I8,
    ST_BIT, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_N0, ST_N1,
    ST_V0, ST_V1, ST_V2, ST_V3, ST_V4,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7, ST_E8, ST_E9,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
    ST_W, ST_PD, ST_O0, ST_O1, ST_O2,
    ST_RD, ST_EXEC, ST_BUSY
  } st_t;

  typedef enum logic [1:0] {WB_CALC, WB_ZERO, WB_RUN} wb_t;

  typedef struct packed {
    op_t                   op;
    slot_t                 ra;
    slot_t                 rb;
    slot_t                 dst;
    logic [FIELD_BITS-1:0] imm;
    st_t                   ret;
  } uop_t;

  logic [FIELD_BITS-1:0] curve_a, field_modulus;

  st_t                    state;
  uop_t                   uq;
  logic [SCALAR_BITS-1:0] k;
  logic [FIELD_BITS-1:0]  px, py;
  logic                   dbl;
  wb_t                    wmode;
  logic [1:0]             widx;
  logic                   f_eq, f_az, f_bz;
  logic [FIELD_BITS-1:0]  alu_acc, alu_sh, alu_opd, alu_q;
  logic [CW-1:0]          cnt;
  logic                   isdiv;
  logic                   out_v;
  logic [FIELD_BITS-1:0]  out_x, out_y;

  logic [FIELD_BITS-1:0]  mem [16];
  logic [FIELD_BITS-1:0]  rda, rdb;
  logic                   we;
  logic [FIELD_BITS-1:0]  wd;

  function automatic logic [FIELD_BITS-1:0] madd(input logic [FIELD_BITS-1:0] u,
                                                 input logic [FIELD_BITS-1:0] v,
                                                 input logic [FIELD_BITS-1:0] m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FIELD_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] msub(input logic [FIELD_BITS-1:0] u,
                                                 input logic [FIELD_BITS-1:0] v,
                                                 input logic [FIELD_BITS-1:0] m);
    return (u >= v) ? (u - v) : (m - (v - u));
  endfunction

  function automatic uop_t uo(input op_t op, input slot_t ra, input slot_t rb,
                              input slot_t dst, input st_t ret);
    uop_t u;
    u.op = op; u.ra = ra; u.rb = rb; u.dst = dst; u.imm = '0; u.ret = ret;
    return u;
  endfunction

  function automatic uop_t ld(input slot_t dst, input logic [FIELD_BITS-1:0] imm,
                              input st_t ret);
    uop_t u;
    u = uo(OP_LDI, dst, dst, dst, ret);
    u.imm = imm;
    return u;
  endfunction

  // p operand is also the destination: run on a doubling pass, acc otherwise
  slot_t p_x, p_y, p_xr, p_yr, w_src, w_dst;
  op_t   w_op;

  always_comb begin
    p_x  = dbl ? SL_RX  : SL_QX;
    p_y  = dbl ? SL_RY  : SL_QY;
    p_xr = dbl ? SL_RXR : SL_QXR;
    p_yr = dbl ? SL_RYR : SL_QYR;
    case (widx)
      2'd0:    w_dst = p_xr;
      2'd1:    w_dst = p_yr;
      2'd2:    w_dst = p_x;
      default: w_dst = p_y;
    endcase
    if (wmode == WB_RUN) begin
      case (widx)
        2'd0:    w_src = SL_RXR;
        2'd1:    w_src = SL_RYR;
        2'd2:    w_src = SL_RX;
        default: w_src = SL_RY;
      endcase
    end else begin
      w_src = widx[0] ? SL_R1 : SL_R0;
    end
    w_op = (wmode == WB_ZERO) ? OP_LDI : OP_MOV;
  end

  // ALU single-bit steps
  logic [FIELD_BITS-1:0] m_dbl, m_nxt, rem_new, quo_new, step_val;
  logic [FIELD_BITS:0]   rem_sh, rem_sub;
  logic                  ge;

  always_comb begin
    m_dbl    = madd(alu_acc, alu_acc, field_modulus);
    m_nxt    = alu_sh[FIELD_BITS-1] ? madd(m_dbl, alu_opd, field_modulus) : m_dbl;
    rem_sh   = {alu_acc, alu_sh[FIELD_BITS-1]};
    rem_sub  = rem_sh - {1'b0, alu_opd};
    ge       = rem_sh >= {1'b0, alu_opd};
    rem_new  = ge ? rem_sub[FIELD_BITS-1:0] : rem_sh[FIELD_BITS-1:0];
    quo_new  = {alu_sh[FIELD_BITS-2:0], ge};
    step_val = isdiv ? rem_new : m_nxt;
  end

  // write-back port; a slot is never read in the cycle it is written
  always_comb begin
    we = 1'b0;
    wd = rda;
    case (state)
      ST_EXEC: begin
        case (uq.op)
          OP_LDI:  begin we = 1'b1; wd = uq.imm; end
          OP_MOV:  begin we = 1'b1; wd = rda; end
          OP_ADD:  begin we = 1'b1; wd = madd(rda, rdb, field_modulus); end
          OP_SUB:  begin we = 1'b1; wd = msub(rda, rdb, field_modulus); end
          default: we = 1'b0;
        endcase
      end
      ST_BUSY: begin
        we = (cnt == '0);
        wd = step_val;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[uq.dst] <= wd;
    rda <= mem[uq.ra];
    rdb <= mem[uq.rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a       <= A_RESET;
      field_modulus <= M_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_A: curve_a       <= cfg_data;
        CFG_MODULUS: field_modulus <= cfg_data;
        default:     curve_a       <= curve_a;
      endcase
    end
  end

  assign job.ready    = (state == ST_IDLE);
  assign res.valid    = out_v;
  assign res.result_x = out_x;
  assign res.result_y = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_v <= 1'b0;
      dbl   <= 1'b0;
      wmode <= WB_CALC;
      widx  <= '0;
      cnt   <= '0;
      isdiv <= 1'b0;
      uq    <= uo(OP_CMP, SL_QXR, SL_QYR, SL_QXR, ST_IDLE);
    end else begin
      // ST_O2 reloads the output register itself
      if (res.ready && state != ST_O2) out_v <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job.valid) begin
            k     <= (field_modulus == '0) ? '0 : job.scalar;
            px    <= job.point_x;
            py    <= job.point_y;
            state <= ST_I0;
          end
        end
        ST_I0: begin uq <= ld(SL_QXR, '0, ST_I1); state <= ST_RD; end
        ST_I1: begin uq <= ld(SL_QYR, '0, ST_I2); state <= ST_RD; end
        ST_I2: begin
          if (k == '0) state <= ST_O0;
          else begin uq <= ld(SL_RXR, px, ST_I3); state <= ST_RD; end
        end
        ST_I3: begin uq <= ld(SL_RYR, py, ST_I4); state <= ST_RD; end
        ST_I4: begin uq <= uo(OP_RED, SL_RXR, SL_RXR, SL_RX, ST_I5); state <= ST_RD; end
        ST_I5: begin uq <= uo(OP_RED, SL_RYR, SL_RYR, SL_RY, ST_I6); state <= ST_RD; end
        ST_I6: begin
          uq <= ld(SL_ONE, (field_modulus == FIELD_BITS'(1)) ? '0 : FIELD_BITS'(1), ST_I7);
          state <= ST_RD;
        end
        ST_I7: begin uq <= ld(SL_DEN, curve_a, ST_I8); state <= ST_RD; end
        ST_I8: begin uq <= uo(OP_RED, SL_DEN, SL_DEN, SL_AR, ST_BIT); state <= ST_RD; end

        ST_BIT: begin
          if (k == '0) state <= ST_O0;
          else begin
            dbl   <= ~k[0];
            state <= ST_A0;
          end
        end
        ST_PD: begin
          if (!dbl) begin
            dbl   <= 1'b1;
            state <= ST_A0;
          end else begin
            k     <= k >> 1;
            state <= ST_BIT;
          end
        end

        // special cases: infinity operands, then raw equality selects doubling
        ST_A0: begin uq <= uo(OP_CMP, p_xr, p_yr, SL_DEN, ST_A1); state <= ST_RD; end
        ST_A1: begin
          if (f_az && f_bz) begin
            if (dbl) state <= ST_PD;
            else begin
              wmode <= WB_RUN;
              widx  <= '0;
              state <= ST_W;
            end
          end else begin
            uq <= uo(OP_CMP, SL_RXR, SL_RYR, SL_DEN, ST_A2); state <= ST_RD;
          end
        end
        ST_A2: begin
          if (f_az && f_bz) state <= ST_PD;
          else begin uq <= uo(OP_CMP, p_xr, SL_RXR, SL_DEN, ST_A3); state <= ST_RD; end
        end
        ST_A3: begin
          if (!f_eq) state <= ST_N0;
          else begin uq <= uo(OP_CMP, p_yr, SL_RYR, SL_DEN, ST_A4); state <= ST_RD; end
        end
        ST_A4: state <= f_eq ? ST_D0 : ST_N0;

        // doubling: num = 3x^2 + a, den = 2y
        ST_D0: begin uq <= uo(OP_MUL, p_x, p_x, SL_NUM, ST_D1); state <= ST_RD; end
        ST_D1: begin uq <= uo(OP_ADD, SL_NUM, SL_NUM, SL_DEN, ST_D2); state <= ST_RD; end
        ST_D2: begin uq <= uo(OP_ADD, SL_DEN, SL_NUM, SL_NUM, ST_D3); state <= ST_RD; end
        ST_D3: begin uq <= uo(OP_ADD, SL_NUM, SL_AR, SL_NUM, ST_D4); state <= ST_RD; end
        ST_D4: begin uq <= uo(OP_ADD, p_y, p_y, SL_DEN, ST_V0); state <= ST_RD; end
        ST_N0: begin uq <= uo(OP_SUB, SL_RY, p_y, SL_NUM, ST_N1); state <= ST_RD; end
        ST_N1: begin uq <= uo(OP_SUB, SL_RX, p_x, SL_DEN, ST_V0); state <= ST_RD; end

        ST_V0: begin uq <= uo(OP_CMP, SL_DEN, SL_DEN, SL_DEN, ST_V1); state <= ST_RD; end
        ST_V1: begin
          if (f_az) begin
            wmode <= WB_ZERO;
            widx  <= '0;
            state <= ST_W;
          end else begin
            uq <= uo(OP_MOV, SL_DEN, SL_DEN, SL_R1, ST_V2); state <= ST_RD;
          end
        end
        ST_V2: begin uq <= ld(SL_R0, field_modulus, ST_V3); state <= ST_RD; end
        ST_V3: begin uq <= ld(SL_T0, '0, ST_V4); state <= ST_RD; end
        ST_V4: begin uq <= uo(OP_MOV, SL_ONE, SL_ONE, SL_T1, ST_E0); state <= ST_RD; end

        // extended Euclid: (r0,r1) <- (r1, r0 % r1), (t0,t1) <- (t1, t0 - q*t1)
        ST_E0: begin uq <= uo(OP_DIV, SL_R0, SL_R1, SL_DEN, ST_E1); state <= ST_RD; end
        ST_E1: begin uq <= uo(OP_MOV, SL_R1, SL_R1, SL_R0, ST_E2); state <= ST_RD; end
        ST_E2: begin uq <= uo(OP_MOV, SL_DEN, SL_DEN, SL_R1, ST_E3); state <= ST_RD; end
        ST_E3: begin uq <= uo(OP_MULQ, SL_T1, SL_T1, SL_DEN, ST_E4); state <= ST_RD; end
        ST_E4: begin uq <= uo(OP_SUB, SL_T0, SL_DEN, SL_DEN, ST_E5); state <= ST_RD; end
        ST_E5: begin uq <= uo(OP_MOV, SL_T1, SL_T1, SL_T0, ST_E6); state <= ST_RD; end
        ST_E6: begin uq <= uo(OP_MOV, SL_DEN, SL_DEN, SL_T1, ST_E7); state <= ST_RD; end
        ST_E7: begin uq <= uo(OP_CMP, SL_R1, SL_ONE, SL_DEN, ST_E8); state <= ST_RD; end
        ST_E8: begin
          if (!f_az) state <= ST_E0;
          else begin uq <= uo(OP_CMP, SL_R0, SL_ONE, SL_DEN, ST_E9); state <= ST_RD; end
        end
        ST_E9: begin
          if (!f_eq) begin
            wmode <= WB_ZERO;
            widx  <= '0;
            state <= ST_W;
          end else begin
            uq <= uo(OP_MUL, SL_T0, SL_NUM, SL_NUM, ST_F0); state <= ST_RD;
          end
        end

        // x3 = s^2 - x1 - x2, y3 = s(x1 - x3) - y1
        ST_F0: begin uq <= uo(OP_MUL, SL_NUM, SL_NUM, SL_DEN, ST_F1); state <= ST_RD; end
        ST_F1: begin uq <= uo(OP_SUB, SL_DEN, p_x, SL_DEN, ST_F2); state <= ST_RD; end
        ST_F2: begin uq <= uo(OP_SUB, SL_DEN, SL_RX, SL_R0, ST_F3); state <= ST_RD; end
        ST_F3: begin uq <= uo(OP_SUB, p_x, SL_R0, SL_DEN, ST_F4); state <= ST_RD; end
        ST_F4: begin uq <= uo(OP_MUL, SL_NUM, SL_DEN, SL_DEN, ST_F5); state <= ST_RD; end
        ST_F5: begin
          uq    <= uo(OP_SUB, SL_DEN, p_y, SL_R1, ST_W);
          wmode <= WB_CALC;
          widx  <= '0;
          state <= ST_RD;
        end

        ST_W: begin
          uq       <= uo(w_op, w_src, w_src, w_dst, (widx == 2'd3) ? ST_PD : ST_W);
          widx     <= widx + 2'd1;
          state    <= ST_RD;
        end

        ST_O0: begin uq <= uo(OP_CMP, SL_QXR, SL_QYR, SL_DEN, ST_IDLE); state <= ST_O1; end
        ST_O1: state <= ST_O2;
        ST_O2: begin
          if (!out_v || res.ready) begin
            out_x <= rda;
            out_y <= rdb;
            out_v <= 1'b1;
            state <= ST_IDLE;
          end
        end

        ST_RD: state <= ST_EXEC;
        ST_EXEC: begin
          case (uq.op)
            OP_CMP: begin
              f_eq  <= (rda == rdb);
              f_az  <= (rda == '0);
              f_bz  <= (rdb == '0);
              state <= uq.ret;
            end
            OP_MUL: begin
              alu_acc <= '0; alu_opd <= rda; alu_sh <= rdb; isdiv <= 1'b0;
              cnt <= CW'(FIELD_BITS - 1); state <= ST_BUSY;
            end
            OP_MULQ: begin
              alu_acc <= '0; alu_opd <= rda; isdiv <= 1'b0;
              alu_sh  <= (alu_q == field_modulus) ? '0 : alu_q;
              cnt <= CW'(FIELD_BITS - 1); state <= ST_BUSY;
            end
            OP_DIV: begin
              alu_acc <= '0; alu_sh <= rda; alu_opd <= rdb; isdiv <= 1'b1;
              cnt <= CW'(FIELD_BITS - 1); state <= ST_BUSY;
            end
            OP_RED: begin
              alu_acc <= '0; alu_sh <= rda; alu_opd <= field_modulus; isdiv <= 1'b1;
              cnt <= CW'(FIELD_BITS - 1); state <= ST_BUSY;
            end
            default: state <= uq.ret;
          endcase
        end
        ST_BUSY: begin
          alu_acc <= step_val;
          alu_sh  <= isdiv ? quo_new : (alu_sh << 1);
          cnt     <= cnt - CW'(1);
          if (cnt == '0) begin
            if (isdiv) alu_q <= quo_new;
            state <= uq.ret;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY && isdiv) |-> (alu_opd != '0))
    else $error("division by zero in ALU");

  a_mulq_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && uq.op == OP_MULQ) |-> (rda < field_modulus))
    else $error("Euclid coefficient not reduced");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> !we)
    else $error("store written during operand read");

  a_job_starts: assert property (@(posedge clk) disable iff (rst)
    (job.valid && job.ready) |=> (state == ST_I0 && !job.ready))
    else $error("accepted job did not start");

endmodule

// ===== dv/ec_scalar_multiply_binary_core_tb.sv =====
// ----------------------------------------------------------------------------
// ec_scalar_multiply_binary_core_tb: self-checking bench for the EC multiplier
// Drives job items (directed table, then random phases under several curve and
// modulus settings) with random gaps on both channels, predicts kP with a
// double-and-add model of its own, and checks every result item in order.
// ----------------------------------------------------------------------------
module ec_scalar_multiply_binary_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int SB = 31;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 18;

  typedef bit [63:0] fe_t;
  typedef struct packed { fe_t x; fe_t y; } ec_point_t;

  typedef struct packed {
    bit [SB-1:0] k;
    bit [FB-1:0] x;
    bit [FB-1:0] y;
    bit          lit;
    bit [FB-1:0] ex;
    bit [FB-1:0] ey;
  } job_row_t;

  typedef struct packed {
    bit          lit;
    bit [FB-1:0] ex;
    bit [FB-1:0] ey;
  } job_tag_t;

  typedef struct packed { bit [FB-1:0] x; bit [FB-1:0] y; } kp_t;

  localparam bit [SB-1:0] KMAX = {SB{1'b1}};

  // directed rows, run with the reset settings (a = 1, modulus 17)
  localparam job_row_t DIRECTED [14] = '{
    '{31'd0,        16'd5,     16'd1,     1'b1, 16'd0,     16'd0},
    '{KMAX,         16'd0,     16'd0,     1'b1, 16'd0,     16'd0},
    '{31'd1,        16'd5,     16'd1,     1'b1, 16'd5,     16'd1},
    '{31'd1,        16'hFFFF,  16'hFFFF,  1'b1, 16'hFFFF,  16'hFFFF},
    '{31'd2,        16'd3,     16'd0,     1'b1, 16'd0,     16'd0},
    '{31'd2,        16'd5,     16'd1,     1'b0, 16'd0,     16'd0},
    '{KMAX,         16'd5,     16'd1,     1'b0, 16'd0,     16'd0},
    '{KMAX,         16'hFFFF,  16'hFFFF,  1'b0, 16'd0,     16'd0},
    '{31'd3,        16'd20,    16'd1,     1'b0, 16'd0,     16'd0},
    '{31'd5,        16'd0,     16'd7,     1'b0, 16'd0,     16'd0},
    '{31'h2AAAAAAA, 16'd10,    16'd3,     1'b0, 16'd0,     16'd0},
    '{31'h55555555, 16'd7,     16'd16,    1'b0, 16'd0,     16'd0},
    '{31'd6,        16'd16,    16'd16,    1'b0, 16'd0,     16'd0},
    '{31'd7,        16'd17,    16'd0,     1'b0, 16'd0,     16'd0}
  };

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [FB-1:0]                 cfg_data = '0;

  ecsm_in_if  #(.SCALAR_BITS(SB), .FIELD_BITS(FB)) job_ch ();
  ecsm_out_if #(.FIELD_BITS(FB))                   res_ch ();

  ec_scalar_multiply_binary_core #(.FIELD_BITS(FB), .SCALAR_BITS(SB)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job_ch.sink),
    .res       (res_ch.source)
  );

  always #10 clk = ~clk;

  fe_t      curve_a_sh = 1;
  fe_t      modulus_sh = 17;
  job_tag_t tag_q[$];
  kp_t      kp_q[$];
  int       err_cnt = 0;
  int       idle_cycles = 0;
  bit       hold_off_req = 1'b0;

  initial begin
    job_ch.valid = 1'b0;
    job_ch.scalar = '0;
    job_ch.point_x = '0;
    job_ch.point_y = '0;
    res_ch.ready = 1'b0;
  end

  // ---- field and curve arithmetic -------------------------------------------
  function automatic fe_t f_add(fe_t u, fe_t v, fe_t m);
    fe_t s;
    s = u + v;
    if (s >= m) s -= m;
    return s;
  endfunction

  function automatic fe_t f_sub(fe_t u, fe_t v, fe_t m);
    return (u >= v) ? (u - v) : (m - (v - u));
  endfunction

  function automatic fe_t f_mul(fe_t u, fe_t v, fe_t m);
    return (u * v) % m;
  endfunction

  // extended Euclid; ok clears when gcd(d, m) != 1
  function automatic fe_t f_inv(fe_t d, fe_t m, output bit ok);
    fe_t r0, r1, t0, t1, q, nr, nt;
    r0 = m;
    r1 = d;
    t0 = 0;
    t1 = (m > 1) ? 1 : 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = f_sub(t0, f_mul(q % m, t1, m), m);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    ok = (r0 == 1);
    return t0;
  endfunction

  function automatic ec_point_t point_sum(ec_point_t p, ec_point_t q, fe_t m, fe_t a);
    ec_point_t r;
    fe_t x1, y1, x2, y2, num, den, inv, s;
    bit ok;
    r = '0;
    if (p.x == 0 && p.y == 0) return q;
    if (q.x == 0 && q.y == 0) return p;
    x1 = p.x % m;
    y1 = p.y % m;
    x2 = q.x % m;
    y2 = q.y % m;
    // doubling is chosen on the raw coordinates, not the reduced ones
    if (p.x == q.x && p.y == q.y) begin
      num = f_add(f_mul(3 % m, f_mul(x1, x1, m), m), a % m, m);
      den = f_add(y1, y1, m);
    end else begin
      num = f_sub(y2, y1, m);
      den = f_sub(x2, x1, m);
    end
    if (den == 0) return r;
    inv = f_inv(den, m, ok);
    if (!ok) return r;
    s = f_mul(inv, num, m);
    r.x = f_sub(f_sub(f_mul(s, s, m), x1, m), x2, m);
    r.y = f_sub(f_mul(s, f_sub(x1, r.x, m), m), y1, m);
    return r;
  endfunction

  function automatic kp_t scalar_multiple(bit [SB-1:0] k, bit [FB-1:0] x, bit [FB-1:0] y);
    ec_point_t acc, run;
    kp_t r;
    acc = '0;
    run.x = fe_t'(x);
    run.y = fe_t'(y);
    if (modulus_sh != 0) begin
      while (k != 0) begin
        if (k[0]) acc = point_sum(acc, run, modulus_sh, curve_a_sh);
        run = point_sum(run, run, modulus_sh, curve_a_sh);
        k = k >> 1;
      end
    end
    r.x = acc.x[FB-1:0];
    r.y = acc.y[FB-1:0];
    return r;
  endfunction

  // ---- monitors -------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    job_tag_t tg;
    kp_t      pk, want;
    if (!rst) begin
      if (job_ch.valid && job_ch.ready) begin
        tg = tag_q.pop_front();
        want = scalar_multiple(job_ch.scalar, job_ch.point_x, job_ch.point_y);
        if (tg.lit) begin
          if (want.x != tg.ex || want.y != tg.ey)
            $display("note: directed value disagrees with prediction");
          want.x = tg.ex;
          want.y = tg.ey;
        end
        kp_q.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (kp_q.size() == 0) begin
          report("unexpected result item x", int'(res_ch.result_x), 0);
        end else begin
          pk = kp_q.pop_front();
          if (res_ch.result_x !== pk.x)
            report("result_x", int'(res_ch.result_x), int'(pk.x));
          if (res_ch.result_y !== pk.y)
            report("result_y", int'(res_ch.result_y), int'(pk.y));
        end
      end
      if ((job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** ec_scalar_multiply_binary_core: FAILED **");
        $finish;
      end
    end
  end

  // ---- result side: random stalls, one long hold-off on request -------------
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 150) : $urandom_range(0, 2);
  endfunction

  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        n = 4000;
        hold_off_req = 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  // ---- job side --------------------------------------------------------------
  task automatic send_job(bit [SB-1:0] k, bit [FB-1:0] x, bit [FB-1:0] y, job_tag_t tg);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      job_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tag_q.push_back(tg);
    job_ch.scalar  <= k;
    job_ch.point_x <= x;
    job_ch.point_y <= y;
    job_ch.valid   <= 1'b1;
    do @(posedge clk); while (!(job_ch.valid && job_ch.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [ecsm_pkg::CFG_IDX_W-1:0] idx, bit [FB-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ecsm_pkg::CFG_CURVE_A) curve_a_sh = fe_t'(val);
    else modulus_sh = fe_t'(val);
  endtask

  task automatic drain();
    job_ch.valid <= 1'b0;
    while (kp_q.size() != 0 || tag_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic bit [SB-1:0] rand_scalar();
    int r, nb;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    nb = (r < 78) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 14) : SB;
    return SB'({$urandom, $urandom} & ((64'd1 << nb) - 1));
  endfunction

  initial begin
    bit [FB-1:0] a_set [5] = '{16'd0, 16'hFFFF, 16'd2, 16'hFFFF, 16'd7};
    bit [FB-1:0] m_set [5] = '{16'd3, 16'd65521, 16'd97, 16'hFFFF, 16'd65521};
    job_tag_t tg;
    bit [FB-1:0] x, y;
    int r;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      tg = '{DIRECTED[i].lit, DIRECTED[i].ex, DIRECTED[i].ey};
      send_job(DIRECTED[i].k, DIRECTED[i].x, DIRECTED[i].y, tg);
    end
    drain();

    foreach (m_set[p]) begin
      write_reg(ecsm_pkg::CFG_CURVE_A, a_set[p]);
      write_reg(ecsm_pkg::CFG_MODULUS, m_set[p]);
      if (p == 1) hold_off_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 9);
        x = FB'($urandom_range(0, m_set[p] - 1));
        y = FB'($urandom_range(0, m_set[p] - 1));
        if (r == 0) begin
          x = '0;
          y = '0;
        end else if (r == 1) begin
          x = FB'($urandom);
          y = FB'($urandom);
        end else if (r == 2) begin
          y = '0;
        end
        send_job(rand_scalar(), x, y, '0);
      end
      drain();
    end

    if (kp_q.size() != 0) report("items left unanswered", 0, kp_q.size());
    if (err_cnt == 0) begin
      $display("** ec_scalar_multiply_binary_core: PASSED **");
    end else begin
      $display("** ec_scalar_multiply_binary_core: FAILED **");
    end
    $finish;
  end

endmodule
